// ----- sv/hrlp_pkg.sv -----
// Shared types, codes and match strings for the HTTP request line parser.
package hrlp_pkg;

  localparam int unsigned LimitWidth = 12;

  localparam logic [LimitWidth-1:0] LimitReset = 12'd255;
  localparam logic [LimitWidth-1:0] CountMax   = 12'hFFF;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusNotGet = 2'd1;
  localparam logic [1:0] StatusBad    = 2'd2;
  localparam logic [1:0] VerdictPend  = 2'd3;

  localparam logic KindPath   = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2F;

  // element 0 is the first character to match
  localparam logic [3:0][7:0] GetWord = {8'h20, 8'h54, 8'h45, 8'h47};
  localparam logic [4:0][7:0] VerWord = {8'h2F, 8'h50, 8'h54, 8'h54, 8'h48};

  localparam logic [2:0] MethodHit  = 3'd4;
  localparam logic [2:0] MethodMiss = 3'd5;
  localparam logic [2:0] VerLen     = 3'd5;

  typedef struct packed {
    logic                  kind;
    logic [7:0]            path_byte;
    logic [1:0]            status;
    logic [LimitWidth-1:0] path_length;
  } hrlp_res_t;

endpackage

// ----- sv/http_request_line_parser.sv -----
// Top level of the HTTP request line parser: streams, APB port and parser.
//
// One request byte is taken per clock cycle while s_tready is high and parsed in that
// same cycle; the word it causes (a path byte or the final status) is registered in the
// result register or the skid entry. A result register plus one skid entry part the two
// streams, so the slave side only stalls while both hold an untaken word. Bytes after the
// CR LF CR LF terminator give nothing until a word with start_req set begins a new
// request. The path limit must be written over APB at address 0 (decoded at 0 to 3)
// only while the block is idle; the block itself does not enforce this.
module http_request_line_parser
  import hrlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] path_byte, [9:8] status, [21:10] path_length
  output logic        m_tuser,   // [0] result_kind
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LimitWidth-1:0] path_limit;
  logic                  accept;
  logic                  res_valid;
  hrlp_res_t             res;
  hrlp_res_t             out_res;

  assign accept = s_tvalid && s_tready;

  hrlp_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .path_limit (path_limit)
  );

  hrlp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (s_tdata),
    .start_req  (s_tuser),
    .path_limit (path_limit),
    .res_valid  (res_valid),
    .res        (res)
  );

  hrlp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  assign m_tuser = out_res.kind;
  assign m_tdata = {2'b00, out_res.path_length, out_res.status, out_res.path_byte};

endmodule

// ----- sv/hrlp_cfg.sv -----
// APB register file holding the path length limit.
module hrlp_cfg
  import hrlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [LimitWidth-1:0] path_limit
);

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      path_limit <= LimitReset;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      path_limit <= pwdata[LimitWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (!paddr[2]) begin
      prdata = {{(32-LimitWidth){1'b0}}, path_limit};
    end
  end

endmodule

// ----- sv/hrlp_core.sv -----
// Byte-wise parser: request line state, terminator watch and result build.
module hrlp_core
  import hrlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  start_req,
  input  logic [LimitWidth-1:0] path_limit,
  output logic                  res_valid,
  output hrlp_res_t             res
);

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_PATH    = 3'd1,
    PH_VERSION = 3'd2,
    PH_HEADERS = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  phase_t                phase, phase_next;
  logic [2:0]            mmc, mmc_next;
  logic [1:0]            verdict, verdict_next;
  logic                  tok, tok_next;
  logic [LimitWidth-1:0] pcount, pcount_next;
  logic                  perr, perr_next;
  logic [2:0]            vmc, vmc_next;
  logic                  vok, vok_next;
  logic [1:0]            tmc, tmc_next;

  phase_t                ph_c;
  logic [2:0]            mmc_c;
  logic [1:0]            verdict_c;
  logic                  tok_c;
  logic [LimitWidth-1:0] pcount_c;
  logic                  perr_c;
  logic [2:0]            vmc_c;
  logic                  vok_c;
  logic [1:0]            tmc_c;
  logic                  complete;
  logic [1:0]            fstat;

  always_comb begin
    // start of a new request clears the parser before this byte
    ph_c      = start_req ? PH_METHOD : phase;
    mmc_c     = start_req ? 3'd0 : mmc;
    verdict_c = start_req ? VerdictPend : verdict;
    tok_c     = start_req ? 1'b0 : tok;
    pcount_c  = start_req ? '0 : pcount;
    perr_c    = start_req ? 1'b0 : perr;
    vmc_c     = start_req ? 3'd0 : vmc;
    vok_c     = start_req ? 1'b0 : vok;
    tmc_c     = start_req ? 2'd0 : tmc;

    if (ph_c == PH_HEADERS && mmc_c == MethodHit) begin
      fstat = (!perr_c && pcount_c != '0 && pcount_c < path_limit && vok_c) ?
              StatusOk : StatusBad;
    end else if (ph_c == PH_HEADERS || ph_c == PH_METHOD) begin
      fstat = (verdict_c == StatusNotGet) ? StatusNotGet : StatusBad;
    end else begin
      fstat = StatusBad;
    end

    phase_next   = ph_c;
    mmc_next     = mmc_c;
    verdict_next = verdict_c;
    tok_next     = tok_c;
    pcount_next  = pcount_c;
    perr_next    = perr_c;
    vmc_next     = vmc_c;
    vok_next     = vok_c;
    tmc_next     = tmc_c;
    complete     = 1'b0;
    res_valid    = 1'b0;
    res          = '0;

    if (ph_c != PH_DONE) begin
      if (data_byte == ChCr) begin
        tmc_next = (tmc_c == 2'd2) ? 2'd3 : 2'd1;
      end else if (data_byte == ChLf && tmc_c == 2'd1) begin
        tmc_next = 2'd2;
      end else if (data_byte == ChLf && tmc_c == 2'd3) begin
        complete = 1'b1;
        tmc_next = 2'd0;
      end else begin
        tmc_next = 2'd0;
      end

      if (complete) begin
        res_valid       = 1'b1;
        res.kind        = KindStatus;
        res.status      = fstat;
        res.path_length = pcount_c;
        phase_next      = PH_DONE;
      end else begin
        unique case (ph_c)
          PH_METHOD: begin
            if (mmc_c < MethodHit) begin
              mmc_next = (data_byte == GetWord[mmc_c[1:0]]) ? mmc_c + 3'd1 : MethodMiss;
            end
            if (verdict_c == VerdictPend) begin
              if (data_byte == ChSpace) begin
                verdict_next = tok_c ? StatusNotGet : StatusBad;
              end else if (data_byte == ChCr) begin
                verdict_next = StatusBad;
              end else begin
                tok_next = 1'b1;
              end
            end
            if (mmc_next == MethodHit) begin
              phase_next = PH_PATH;
            end else if (mmc_next > MethodHit && verdict_next != VerdictPend) begin
              phase_next = PH_HEADERS;
            end
          end
          PH_PATH: begin
            if (data_byte == ChSpace) begin
              phase_next = PH_VERSION;
              vmc_next   = 3'd0;
            end else begin
              if (pcount_c == '0 && data_byte != ChSlash) begin
                perr_next = 1'b1;
              end
              if (pcount_c < path_limit && pcount_c != CountMax) begin
                pcount_next = pcount_c + 1'b1;
              end else begin
                perr_next = 1'b1;
              end
              res_valid     = 1'b1;
              res.kind      = KindPath;
              res.path_byte = data_byte;
            end
          end
          PH_VERSION: begin
            if (vmc_c < VerLen && data_byte == VerWord[vmc_c]) begin
              vmc_next = vmc_c + 3'd1;
              if (vmc_next == VerLen) begin
                vok_next   = 1'b1;
                phase_next = PH_HEADERS;
              end
            end else begin
              phase_next = PH_HEADERS;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_METHOD;
      mmc     <= 3'd0;
      verdict <= VerdictPend;
      tok     <= 1'b0;
      pcount  <= '0;
      perr    <= 1'b0;
      vmc     <= 3'd0;
      vok     <= 1'b0;
      tmc     <= 2'd0;
    end else if (accept) begin
      phase   <= phase_next;
      mmc     <= mmc_next;
      verdict <= verdict_next;
      tok     <= tok_next;
      pcount  <= pcount_next;
      perr    <= perr_next;
      vmc     <= vmc_next;
      vok     <= vok_next;
      tmc     <= tmc_next;
    end
  end

endmodule

// ----- sv/hrlp_out.sv -----
// Result register with one skid entry towards the master stream.
module hrlp_out
  import hrlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  hrlp_res_t in_res,
  output logic      in_ready,
  output logic      out_valid,
  output hrlp_res_t out_res,
  input  logic      out_ready
);

  logic      skid_valid;
  hrlp_res_t skid_res;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_valid) begin
        out_res   <= in_res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_valid) begin
      skid_res   <= in_res;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Testbench for the HTTP request line parser: a directed table, then phases of random requests.
module tb_top;
  import hrlp_pkg::*;

  localparam logic [2:0]  AddrPathLimit = 3'd0;
  localparam int          PhaseItems    = 180;
  localparam int unsigned CycleLimit    = 1000000;

  typedef enum logic [2:0] {InMethod, InPath, InVersion, InHeaders, Finished} parse_phase_e;
  typedef enum logic {ChkModel, ChkWord} row_chk_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    row_chk_e   chk;
    hrlp_res_t  word;
  } dir_row_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;   // [7:0] data_byte
  logic        s_tuser  = 1'b0;   // [0] start_req
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [7:0] path_byte, [9:8] status, [21:10] path_length
  logic        m_tuser;           // [0] result_kind
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = 3'd0;
  logic [31:0] pwdata   = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  http_request_line_parser uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // parse model state
  logic [11:0]  lim_q;
  parse_phase_e ph;
  logic [2:0]   mcnt;
  logic [1:0]   verdict;
  logic         tok_seen;
  logic [11:0]  pcnt;
  logic         perr;
  logic [2:0]   vcnt;
  logic         vok;
  logic [1:0]   tcnt;

  hrlp_res_t   parsed_words [$];
  logic [7:0]  req_q [$];
  dir_row_t    dir_rows [26];
  int          errors      = 0;
  int          words_seen  = 0;
  int          taken       = 0;
  int unsigned cycle_count = 0;
  bit          snd_burst   = 0;
  bit          rcv_burst   = 0;
  bit          long_sent   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("[%0t] %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("word %0d: %s is %0h, want %0h", words_seen, name, got, want));
  endtask

  function automatic void restart_parse();
    ph       = InMethod;
    mcnt     = 3'd0;
    verdict  = VerdictPend;
    tok_seen = 1'b0;
    pcnt     = 12'd0;
    perr     = 1'b0;
    vcnt     = 3'd0;
    vok      = 1'b0;
    tcnt     = 2'd0;
  endfunction

  function automatic logic [1:0] closing_status();
    if (ph == InHeaders && mcnt == MethodHit)
      return (!perr && pcnt != 12'd0 && pcnt < lim_q && vok) ? StatusOk : StatusBad;
    if (ph == InHeaders || ph == InMethod)
      return (verdict == StatusNotGet) ? StatusNotGet : StatusBad;
    return StatusBad;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic st,
                            output bit produced, output hrlp_res_t w, output bit ignored);
    bit complete;
    produced = 0;
    ignored  = 0;
    complete = 0;
    w        = '0;
    if (st) restart_parse();
    if (ph == Finished) begin
      ignored = 1;
      return;
    end
    if (b == ChCr) tcnt = (tcnt == 2'd2) ? 2'd3 : 2'd1;
    else if (b == ChLf && tcnt == 2'd1) tcnt = 2'd2;
    else if (b == ChLf && tcnt == 2'd3) begin
      complete = 1;
      tcnt = 2'd0;
    end else tcnt = 2'd0;
    if (complete) begin
      w.kind        = KindStatus;
      w.status      = closing_status();
      w.path_length = pcnt;
      ph            = Finished;
      produced      = 1;
      return;
    end
    case (ph)
      InMethod: begin
        if (mcnt < MethodHit) mcnt = (b == GetWord[mcnt[1:0]]) ? mcnt + 3'd1 : MethodMiss;
        if (verdict == VerdictPend) begin
          if (b == ChSpace) verdict = tok_seen ? StatusNotGet : StatusBad;
          else if (b == ChCr) verdict = StatusBad;
          else tok_seen = 1'b1;
        end
        if (mcnt == MethodHit) ph = InPath;
        else if (mcnt > MethodHit && verdict != VerdictPend) ph = InHeaders;
      end
      InPath: begin
        if (b == ChSpace) begin
          ph   = InVersion;
          vcnt = 3'd0;
        end else begin
          if (pcnt == 12'd0 && b != ChSlash) perr = 1'b1;
          if (pcnt < lim_q && pcnt < CountMax) pcnt = pcnt + 12'd1;
          else perr = 1'b1;
          w.kind      = KindPath;
          w.path_byte = b;
          produced    = 1;
        end
      end
      InVersion: begin
        if (vcnt < VerLen && b == VerWord[vcnt]) begin
          vcnt = vcnt + 3'd1;
          if (vcnt == VerLen) begin
            vok = 1'b1;
            ph  = InHeaders;
          end
        end else ph = InHeaders;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [7:0] b, input logic st);
    int gap;
    gap = snd_burst ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= b;
    s_tuser  <= st;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (parsed_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [11:0] val, output logic [31:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrPathLimit;
    pwdata  <= {20'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_path_limit(input logic [11:0] val);
    logic [31:0] rd;
    apb_access(1'b1, val, rd);
    lim_q = val;
    apb_access(1'b0, 12'd0, rd);
    if (rd != {20'd0, val})
      report_mismatch($sformatf("path_limit reads %0h after writing %0h", rd, val));
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) req_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] any_path_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    return (c == ChSpace) ? 8'hA0 : c;
  endfunction

  task automatic add_letters(input int n);
    repeat (n) req_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
  endtask

  task automatic build_get();
    int len;
    int k;
    add_str("GET ");
    if (lim_q == 12'd255 && !long_sent) begin
      len = 300;
      long_sent = 1;
    end else if ($urandom_range(0, 9) >= 6 && lim_q <= 12'd300) begin
      len = int'(lim_q) + int'($urandom_range(0, 2)) - 1;
      if (len < 0) len = 0;
    end else len = int'($urandom_range(0, 6));
    for (int i = 0; i < len; i++) begin
      if (i == 0) req_q.push_back(($urandom_range(0, 9) != 0) ? ChSlash : any_path_char());
      else case ($urandom_range(0, 19))
        0:       req_q.push_back(ChCr);
        1:       req_q.push_back(ChLf);
        2, 3:    req_q.push_back(any_path_char());
        default: req_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      add_str("\r\n\r\n");
      return;
    end
    req_q.push_back(ChSpace);
    if ($urandom_range(0, 4) != 0) add_str("HTTP/1.1");
    else begin
      k = int'($urandom_range(0, 4));
      for (int i = 0; i < k; i++) req_q.push_back(VerWord[i]);
      req_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
    end
    add_str("\r\n");
    repeat ($urandom_range(0, 2)) begin
      add_str("Host: ");
      add_letters(int'($urandom_range(1, 4)));
      add_str("\r\n");
    end
    add_str("\r\n");
  endtask

  task automatic build_other();
    case ($urandom_range(0, 5))
      0: add_str("PUT");
      1: add_str("POST");
      2: add_str("HEAD");
      3: ;
      4: case ($urandom_range(0, 5))
           0: add_str("G");
           1: add_str("GE");
           2: add_str("GET");
           3: add_str("GETX");
           4: add_str("GEt");
           default: add_str("gET");
         endcase
      default: repeat ($urandom_range(1, 4)) req_q.push_back(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 4) != 0) add_str(" /p HTTP/1.0");
    add_str("\r\n\r\n");
  endtask

  task automatic emit_request(input bit first_start);
    logic      st;
    bit        prod;
    bit        ign;
    hrlp_res_t w;
    if ($urandom_range(0, 3) == 0) snd_burst = !snd_burst;
    for (int i = 0; i < req_q.size(); i++) begin
      st = (i == 0) ? first_start : ($urandom_range(0, 199) == 0);
      send_word(req_q[i], st);
      parse_byte(req_q[i], st, prod, w, ign);
      if (prod) parsed_words.push_back(w);
      if (!ign) taken++;
    end
    req_q.delete();
    if ($urandom_range(0, 199) == 0) wait_drain();
  endtask

  // result side
  initial begin
    hrlp_res_t want;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rcv_burst = !rcv_burst;
      stall = rcv_burst ? 0 : $urandom_range(0, 17);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      words_seen++;
      if (parsed_words.size() == 0) begin
        report_mismatch($sformatf("word %0d arrived with none due: kind %0b data %0h",
                                  words_seen, m_tuser, m_tdata));
      end else begin
        want = parsed_words.pop_front();
        check_field("result_kind", int'(m_tuser), int'(want.kind));
        check_field("path_byte", int'(m_tdata[7:0]), int'(want.path_byte));
        check_field("status", int'(m_tdata[9:8]), int'(want.status));
        check_field("path_length", int'(m_tdata[21:10]), int'(want.path_length));
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0] rd;
    logic [11:0] limit_plan [9];
    bit          prod;
    bit          ign;
    bit          carry;
    hrlp_res_t   w;
    lim_q = LimitReset;
    restart_parse();
    carry = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_access(1'b0, 12'd0, rd);
    if (rd != {20'd0, LimitReset})
      report_mismatch($sformatf("path_limit reads %0h after reset", rd));

    dir_rows = '{
      // terminator only, no start_req yet
      '{ChCr, 1'b0, ChkModel, '0}, '{ChLf, 1'b0, ChkModel, '0}, '{ChCr, 1'b0, ChkModel, '0},
      '{ChLf, 1'b0, ChkWord, '{KindStatus, 8'h00, StatusBad, 12'd0}},
      // ignored after the terminator
      '{8'hFF, 1'b0, ChkModel, '0},
      // GET / HTTP/ CR LF CR LF
      '{"G", 1'b1, ChkModel, '0}, '{"E", 1'b0, ChkModel, '0}, '{"T", 1'b0, ChkModel, '0},
      '{ChSpace, 1'b0, ChkModel, '0},
      '{ChSlash, 1'b0, ChkWord, '{KindPath, ChSlash, 2'd0, 12'd0}},
      '{ChSpace, 1'b0, ChkModel, '0},
      '{"H", 1'b0, ChkModel, '0}, '{"T", 1'b0, ChkModel, '0}, '{"T", 1'b0, ChkModel, '0},
      '{"P", 1'b0, ChkModel, '0}, '{ChSlash, 1'b0, ChkModel, '0},
      '{ChCr, 1'b0, ChkModel, '0}, '{ChLf, 1'b0, ChkModel, '0}, '{ChCr, 1'b0, ChkModel, '0},
      '{ChLf, 1'b0, ChkWord, '{KindStatus, 8'h00, StatusOk, 12'd1}},
      // one-byte other method
      '{8'h00, 1'b1, ChkModel, '0}, '{ChSpace, 1'b0, ChkModel, '0},
      '{ChCr, 1'b0, ChkModel, '0}, '{ChLf, 1'b0, ChkModel, '0}, '{ChCr, 1'b0, ChkModel, '0},
      '{ChLf, 1'b0, ChkWord, '{KindStatus, 8'h00, StatusNotGet, 12'd0}}
    };
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].data, dir_rows[i].start);
      parse_byte(dir_rows[i].data, dir_rows[i].start, prod, w, ign);
      if (dir_rows[i].chk == ChkWord) parsed_words.push_back(dir_rows[i].word);
      else if (prod) parsed_words.push_back(w);
    end

    limit_plan = '{12'd1, 12'd4095, 12'd0, 12'd2, 12'd0, 12'd255, 12'd3, 12'd0, 12'd8};
    limit_plan[4] = 12'($urandom_range(4, 40));
    limit_plan[7] = 12'($urandom_range(1, 4095));
    foreach (limit_plan[p]) begin
      wait_drain();
      set_path_limit(limit_plan[p]);
      taken = 0;
      if (carry) begin
        add_str(" HTTP/1.1\r\n\r\n");
        emit_request(1'b0);
        carry = 0;
      end
      while (taken < PhaseItems) begin
        case ($urandom_range(0, 99)) inside
          [0:59]:  build_get();
          [60:81]: build_other();
          default: begin
            repeat ($urandom_range(1, 12)) req_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0) add_str("\r\n\r\n");
          end
        endcase
        if ($urandom_range(0, 9) < 3)
          repeat ($urandom_range(1, 3)) req_q.push_back(8'($urandom_range(0, 255)));
        emit_request($urandom_range(0, 19) != 0);
      end
      // leave a request open across the next limit change
      if (p < 8 && $urandom_range(0, 1) == 0) begin
        add_str("GET /");
        repeat ($urandom_range(0, 3)) req_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        emit_request(1'b1);
        carry = 1;
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/hrlp_pkg.sv
sv/hrlp_cfg.sv
sv/hrlp_core.sv
sv/hrlp_out.sv
sv/http_request_line_parser.sv
verif/tb_top.sv
